>>> src/rlq_pkg.sv
// ----------------------------------------------------------------------------
// rlq_pkg
// Shared types, codes and constants of the reservable linked queue unit.
// ----------------------------------------------------------------------------
`default_nettype none

package rlq_pkg;

  // Field widths of the request and response words
  localparam int ACTION_W = 3;
  localparam int HANDLE_W = 4;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;

  // Default pool size
  localparam int DEF_SLOTS = 16;

  // Request actions
  typedef enum logic [ACTION_W-1:0] {
    ACT_APPEND   = 3'd0,
    ACT_INSERT   = 3'd1,
    ACT_RESERVE  = 3'd2,
    ACT_COMMIT   = 3'd3,
    ACT_ROLLBACK = 3'd4
  } action_t;

  // Response status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_DONE   = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_MISUSE = 2'd2
  } status_t;

  // Controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_APPEND_LINK,
    S_INS_LINK1,
    S_INS_LINK2,
    S_WALK,
    S_SEARCH,
    S_COMMIT_FIX
  } state_t;

  // Datapath operations issued by the controller
  typedef enum logic [4:0] {
    OP_NOP,
    OP_LOAD,
    OP_REJECT,
    OP_EMPTY,
    OP_APPEND_SOLO,
    OP_APPEND_CLEAR,
    OP_APPEND_LINK,
    OP_INSERT_HEAD,
    OP_INSERT_READ,
    OP_INSERT_LINK1,
    OP_INSERT_LINK2,
    OP_WALK_START,
    OP_WALK_STEP,
    OP_GRANT,
    OP_READ_SLOT,
    OP_COMMIT_FIX,
    OP_ROLLBACK
  } dp_op_t;

  // Datapath flags seen by the controller
  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic                at_head;
    logic                in_pool;
    logic                after_ok;
    logic                s_queued;
    logic                s_reserved;
    logic                s_is_head;
    logic                count_zero;
    logic                free_zero;
    logic                p_reserved;
    logic                link_hit;
    logic                steps_done;
    logic                out_free;
  } dp_status_t;

  // Operations that load the response register
  function automatic logic op_has_result(input dp_op_t op);
    logic res;
    case (op)
      OP_REJECT, OP_EMPTY, OP_APPEND_SOLO, OP_APPEND_LINK, OP_INSERT_HEAD,
      OP_INSERT_LINK2, OP_GRANT, OP_COMMIT_FIX, OP_ROLLBACK: res = 1'b1;
      default: res = 1'b0;
    endcase
    return res;
  endfunction

endpackage

`default_nettype wire

>>> src/rlq_in_if.sv
// ----------------------------------------------------------------------------
// rlq_in_if
// Request channel: valid/ready handshake with one request word.
// ----------------------------------------------------------------------------
`default_nettype none

interface rlq_in_if;
  logic                          valid;
  logic                          ready;
  logic [rlq_pkg::ACTION_W-1:0]  action;
  logic [rlq_pkg::HANDLE_W-1:0]  slot;
  logic [rlq_pkg::HANDLE_W-1:0]  after_slot;
  logic                          after_is_head;

  modport source (output valid, action, slot, after_slot, after_is_head, input ready);
  modport sink   (input valid, action, slot, after_slot, after_is_head, output ready);
endinterface

`default_nettype wire

>>> src/rlq_out_if.sv
// ----------------------------------------------------------------------------
// rlq_out_if
// Response channel: valid/ready handshake with one response word.
// ----------------------------------------------------------------------------
`default_nettype none

interface rlq_out_if;
  logic                          valid;
  logic                          ready;
  logic [rlq_pkg::STATUS_W-1:0]  status;
  logic [rlq_pkg::HANDLE_W-1:0]  granted_slot;
  logic [rlq_pkg::COUNT_W-1:0]   queued_count;
  logic [rlq_pkg::COUNT_W-1:0]   unreserved_count;

  modport source (output valid, status, granted_slot, queued_count, unreserved_count,
                  input ready);
  modport sink   (input valid, status, granted_slot, queued_count, unreserved_count,
                  output ready);
endinterface

`default_nettype wire

>>> src/rlq_ram.sv
// ----------------------------------------------------------------------------
// rlq_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module rlq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read data holds while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

>>> src/rlq_ctrl.sv
// ----------------------------------------------------------------------------
// rlq_ctrl
// Controller: decodes a request and sequences the list walk in the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module rlq_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  rlq_pkg::dp_status_t st,
  output rlq_pkg::dp_op_t     op
);

  rlq_pkg::state_t state, state_next;
  rlq_pkg::dp_op_t op_raw;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rlq_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Operation wanted in each state
  always_comb begin
    op_raw   = rlq_pkg::OP_NOP;
    in_ready = (state == rlq_pkg::S_IDLE);
    case (state)
      rlq_pkg::S_IDLE: begin
        if (in_valid) op_raw = rlq_pkg::OP_LOAD;
      end
      rlq_pkg::S_DECODE: begin
        case (rlq_pkg::action_t'(st.action))
          rlq_pkg::ACT_APPEND: begin
            if (!st.in_pool || st.s_queued) op_raw = rlq_pkg::OP_REJECT;
            else if (st.count_zero)         op_raw = rlq_pkg::OP_APPEND_SOLO;
            else                            op_raw = rlq_pkg::OP_APPEND_CLEAR;
          end
          rlq_pkg::ACT_INSERT: begin
            if (!st.in_pool || st.s_queued) op_raw = rlq_pkg::OP_REJECT;
            else if (st.at_head)            op_raw = rlq_pkg::OP_INSERT_HEAD;
            else if (!st.after_ok)          op_raw = rlq_pkg::OP_REJECT;
            else                            op_raw = rlq_pkg::OP_INSERT_READ;
          end
          rlq_pkg::ACT_RESERVE: begin
            if (st.free_zero) op_raw = rlq_pkg::OP_EMPTY;
            else              op_raw = rlq_pkg::OP_WALK_START;
          end
          rlq_pkg::ACT_COMMIT: begin
            if (!st.in_pool || !st.s_queued || !st.s_reserved) op_raw = rlq_pkg::OP_REJECT;
            else if (st.s_is_head) op_raw = rlq_pkg::OP_READ_SLOT;
            else                   op_raw = rlq_pkg::OP_WALK_START;
          end
          rlq_pkg::ACT_ROLLBACK: begin
            if (!st.in_pool || !st.s_reserved) op_raw = rlq_pkg::OP_REJECT;
            else                               op_raw = rlq_pkg::OP_ROLLBACK;
          end
          default: op_raw = rlq_pkg::OP_REJECT;
        endcase
      end
      rlq_pkg::S_APPEND_LINK: op_raw = rlq_pkg::OP_APPEND_LINK;
      rlq_pkg::S_INS_LINK1:   op_raw = rlq_pkg::OP_INSERT_LINK1;
      rlq_pkg::S_INS_LINK2:   op_raw = rlq_pkg::OP_INSERT_LINK2;
      // oldest unreserved entry, one link per cycle
      rlq_pkg::S_WALK: begin
        if (st.steps_done)       op_raw = rlq_pkg::OP_EMPTY;
        else if (!st.p_reserved) op_raw = rlq_pkg::OP_GRANT;
        else                     op_raw = rlq_pkg::OP_WALK_STEP;
      end
      // predecessor search for a commit
      rlq_pkg::S_SEARCH: begin
        if (st.steps_done)    op_raw = rlq_pkg::OP_REJECT;
        else if (st.link_hit) op_raw = rlq_pkg::OP_READ_SLOT;
        else                  op_raw = rlq_pkg::OP_WALK_STEP;
      end
      rlq_pkg::S_COMMIT_FIX: op_raw = rlq_pkg::OP_COMMIT_FIX;
      default: op_raw = rlq_pkg::OP_NOP;
    endcase
  end

  // Hold off a response while the output register is still full
  always_comb begin
    op = op_raw;
    if (rlq_pkg::op_has_result(op_raw) && !st.out_free) op = rlq_pkg::OP_NOP;
  end

  // Next state
  always_comb begin
    state_next = state;
    if (rlq_pkg::op_has_result(op)) begin
      state_next = rlq_pkg::S_IDLE;
    end else begin
      case (state)
        rlq_pkg::S_IDLE: begin
          if (op == rlq_pkg::OP_LOAD) state_next = rlq_pkg::S_DECODE;
        end
        rlq_pkg::S_DECODE: begin
          case (op)
            rlq_pkg::OP_APPEND_CLEAR: state_next = rlq_pkg::S_APPEND_LINK;
            rlq_pkg::OP_INSERT_READ:  state_next = rlq_pkg::S_INS_LINK1;
            rlq_pkg::OP_READ_SLOT:    state_next = rlq_pkg::S_COMMIT_FIX;
            rlq_pkg::OP_WALK_START: begin
              if (st.action == rlq_pkg::ACT_RESERVE) state_next = rlq_pkg::S_WALK;
              else                                   state_next = rlq_pkg::S_SEARCH;
            end
            default: state_next = rlq_pkg::S_DECODE;
          endcase
        end
        rlq_pkg::S_INS_LINK1: state_next = rlq_pkg::S_INS_LINK2;
        rlq_pkg::S_SEARCH: begin
          if (op == rlq_pkg::OP_READ_SLOT) state_next = rlq_pkg::S_COMMIT_FIX;
        end
        default: state_next = state;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_result_has_room: assert property (@(posedge clk) disable iff (rst)
    rlq_pkg::op_has_result(op) |-> st.out_free)
    else $error("response issued while output register is full");

  a_load_to_decode: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == rlq_pkg::S_DECODE))
    else $error("accepted word did not reach decode");

  a_walk_bounded: assert property (@(posedge clk) disable iff (rst)
    (op == rlq_pkg::OP_WALK_STEP) |-> !st.steps_done)
    else $error("list walk ran past the entry count");
`endif

endmodule

`default_nettype wire

>>> src/rlq_datapath.sv
// ----------------------------------------------------------------------------
// rlq_datapath
// Queue state, link memory, walk pointer and the response register.
// ----------------------------------------------------------------------------
`default_nettype none

module rlq_datapath #(
  parameter int SLOTS = rlq_pkg::DEF_SLOTS
) (
  input  logic                         clk,
  input  logic                         rst,
  input  rlq_pkg::dp_op_t              op,
  output rlq_pkg::dp_status_t          st,
  input  logic [rlq_pkg::ACTION_W-1:0] action,
  input  logic [rlq_pkg::HANDLE_W-1:0] slot,
  input  logic [rlq_pkg::HANDLE_W-1:0] after_slot,
  input  logic                         after_is_head,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [rlq_pkg::STATUS_W-1:0] status,
  output logic [rlq_pkg::HANDLE_W-1:0] granted_slot,
  output logic [rlq_pkg::COUNT_W-1:0]  queued_count,
  output logic [rlq_pkg::COUNT_W-1:0]  unreserved_count
);

  localparam int IDX_W = $clog2(SLOTS);
  localparam int CNT_W = $clog2(SLOTS + 1);
  localparam int HW    = rlq_pkg::HANDLE_W;
  localparam int CW    = rlq_pkg::COUNT_W;

  // Latched request word
  logic [rlq_pkg::ACTION_W-1:0] act_q;
  logic [HW-1:0]                slot_q, after_q;
  logic                         at_head_q;

  // Queue state
  logic [IDX_W-1:0] head, tail, head_next, tail_next;
  logic [CNT_W-1:0] entry_count, free_count, count_next, free_next;
  logic [SLOTS-1:0] queued, reserved, queued_next, reserved_next;

  // Walk pointer and link counter
  logic [IDX_W-1:0] p, p_next;
  logic [CNT_W-1:0] step, step_next;

  // Link memory port
  logic             we, re;
  logic [IDX_W-1:0] waddr, raddr, wdata, rdata;

  // Response staging
  logic                   res_load, mark;
  rlq_pkg::status_t       res_status;
  logic [IDX_W-1:0]       res_grant;
  logic [IDX_W+HW-1:0]    s_wide, a_wide, g_wide;
  logic [CNT_W+CW-1:0]    qc_wide, uc_wide;
  logic [IDX_W-1:0]       s_idx, a_idx;

  assign s_wide = {{IDX_W{1'b0}}, slot_q};
  assign a_wide = {{IDX_W{1'b0}}, after_q};
  assign s_idx  = s_wide[IDX_W-1:0];
  assign a_idx  = a_wide[IDX_W-1:0];

  rlq_ram #(.WIDTH(IDX_W), .DEPTH(SLOTS)) u_link (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Flags for the controller
  always_comb begin
    st.action     = act_q;
    st.at_head    = at_head_q;
    st.in_pool    = (32'(slot_q) < SLOTS);
    st.after_ok   = (32'(after_q) < SLOTS) && queued[a_idx];
    st.s_queued   = queued[s_idx];
    st.s_reserved = reserved[s_idx];
    st.s_is_head  = (s_idx == head);
    st.count_zero = (entry_count == '0);
    st.free_zero  = (free_count == '0);
    st.p_reserved = reserved[p];
    st.link_hit   = (rdata == s_idx);
    st.steps_done = (step >= entry_count);
    st.out_free   = !out_valid || out_ready;
  end

  // Next state of the queue per operation
  always_comb begin
    head_next     = head;
    tail_next     = tail;
    count_next    = entry_count;
    free_next     = free_count;
    queued_next   = queued;
    reserved_next = reserved;
    p_next        = p;
    step_next     = step;
    we            = 1'b0;
    waddr         = s_idx;
    wdata         = '0;
    re            = 1'b0;
    raddr         = s_idx;
    res_load      = 1'b0;
    res_status    = rlq_pkg::ST_DONE;
    res_grant     = '0;
    mark          = 1'b0;
    case (op)
      rlq_pkg::OP_REJECT: begin
        res_load   = 1'b1;
        res_status = rlq_pkg::ST_MISUSE;
      end
      rlq_pkg::OP_EMPTY: begin
        res_load   = 1'b1;
        res_status = rlq_pkg::ST_EMPTY;
      end
      rlq_pkg::OP_APPEND_SOLO: begin
        we        = 1'b1;
        head_next = s_idx;
        tail_next = s_idx;
        mark      = 1'b1;
        res_load  = 1'b1;
      end
      rlq_pkg::OP_APPEND_CLEAR: begin
        we = 1'b1;
      end
      rlq_pkg::OP_APPEND_LINK: begin
        we        = 1'b1;
        waddr     = tail;
        wdata     = s_idx;
        tail_next = s_idx;
        mark      = 1'b1;
        res_load  = 1'b1;
      end
      rlq_pkg::OP_INSERT_HEAD: begin
        we = 1'b1;
        if (entry_count == '0) tail_next = s_idx;
        else                   wdata     = head;
        head_next = s_idx;
        mark      = 1'b1;
        res_load  = 1'b1;
      end
      rlq_pkg::OP_INSERT_READ: begin
        re    = 1'b1;
        raddr = a_idx;
      end
      rlq_pkg::OP_INSERT_LINK1: begin
        we    = 1'b1;
        wdata = rdata;
      end
      rlq_pkg::OP_INSERT_LINK2: begin
        we    = 1'b1;
        waddr = a_idx;
        wdata = s_idx;
        if (tail == a_idx) tail_next = s_idx;
        mark     = 1'b1;
        res_load = 1'b1;
      end
      rlq_pkg::OP_WALK_START: begin
        re        = 1'b1;
        raddr     = head;
        p_next    = head;
        step_next = '0;
      end
      rlq_pkg::OP_WALK_STEP: begin
        re        = 1'b1;
        raddr     = rdata;
        p_next    = rdata;
        step_next = step + CNT_W'(1);
      end
      rlq_pkg::OP_GRANT: begin
        reserved_next[p] = 1'b1;
        free_next        = free_count - CNT_W'(1);
        res_grant        = p;
        res_load         = 1'b1;
      end
      rlq_pkg::OP_READ_SLOT: begin
        re = 1'b1;
      end
      // unlink: rdata holds the committed slot's successor
      rlq_pkg::OP_COMMIT_FIX: begin
        count_next           = entry_count - CNT_W'(1);
        queued_next[s_idx]   = 1'b0;
        reserved_next[s_idx] = 1'b0;
        if (s_idx == head) begin
          head_next = rdata;
        end else begin
          we    = 1'b1;
          waddr = p;
          wdata = rdata;
          if (tail == s_idx) tail_next = p;
        end
        if (count_next == '0) begin
          head_next = '0;
          tail_next = '0;
        end
        res_load = 1'b1;
      end
      rlq_pkg::OP_ROLLBACK: begin
        reserved_next[s_idx] = 1'b0;
        free_next            = free_count + CNT_W'(1);
        res_load             = 1'b1;
      end
      default: ;
    endcase
    // new entry joins as queued and free
    if (mark) begin
      queued_next[s_idx]   = 1'b1;
      reserved_next[s_idx] = 1'b0;
      count_next           = entry_count + CNT_W'(1);
      free_next            = free_count + CNT_W'(1);
    end
  end

  assign g_wide  = {{HW{1'b0}}, res_grant};
  assign qc_wide = {{CW{1'b0}}, count_next};
  assign uc_wide = {{CW{1'b0}}, free_next};

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      head        <= '0;
      tail        <= '0;
      entry_count <= '0;
      free_count  <= '0;
      queued      <= '0;
      reserved    <= '0;
      out_valid   <= 1'b0;
    end else begin
      head        <= head_next;
      tail        <= tail_next;
      entry_count <= count_next;
      free_count  <= free_next;
      queued      <= queued_next;
      reserved    <= reserved_next;
      if (res_load)       out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    p    <= p_next;
    step <= step_next;
    if (op == rlq_pkg::OP_LOAD) begin
      act_q     <= action;
      slot_q    <= slot;
      after_q   <= after_slot;
      at_head_q <= after_is_head;
    end
    if (res_load) begin
      status           <= res_status;
      granted_slot     <= g_wide[HW-1:0];
      queued_count     <= qc_wide[CW-1:0];
      unreserved_count <= uc_wide[CW-1:0];
    end
  end

`ifndef SYNTHESIS
  a_free_within_count: assert property (@(posedge clk) disable iff (rst)
    free_count <= entry_count)
    else $error("free count exceeds entry count");

  a_reserved_is_queued: assert property (@(posedge clk) disable iff (rst)
    (reserved & ~queued) == '0)
    else $error("reserved slot not in queue");

  a_count_tracks_marks: assert property (@(posedge clk) disable iff (rst)
    $countones(queued) == 32'(entry_count))
    else $error("entry count out of step with queued marks");
`endif

endmodule

`default_nettype wire

>>> src/reservable_linked_queue_unit.sv
// ----------------------------------------------------------------------------
// reservable_linked_queue_unit
// Ordered queue of slot handles kept as a linked list, with reservations.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one request word (action, slot, after_slot, after_is_head);
//   rsp returns exactly one response word per request (status, granted_slot,
//   queued_count, unreserved_count). Both channels use valid/ready.
//   One request is worked on at a time. Append into an empty queue, head
//   insert, rollback and a word rejected at decode are answered from the
//   decode step; append behind the tail adds a link step, and insert after
//   adds a link step for the new slot and one for its predecessor.
//   Reserve and commit walk the list through the link memory's read port,
//   one link per cycle, so their time to response grows with the walk.
//   req is ready again as soon as a response is loaded into the output
//   register; a stalled rsp holds its word, and the next request then
//   waits at its response step until the register is taken.
//   Reset clears the queue, all reservations and the output register; the
//   link memory needs no clearing since each link is written on enqueue.
// ----------------------------------------------------------------------------
`default_nettype none

module reservable_linked_queue_unit #(
  parameter int SLOTS = rlq_pkg::DEF_SLOTS
) (
  input  logic     clk,
  input  logic     rst,
  rlq_in_if.sink   req,
  rlq_out_if.source rsp
);

  rlq_pkg::dp_op_t     op;
  rlq_pkg::dp_status_t st;

  rlq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .st       (st),
    .op       (op)
  );

  rlq_datapath #(.SLOTS(SLOTS)) u_dp (
    .clk              (clk),
    .rst              (rst),
    .op               (op),
    .st               (st),
    .action           (req.action),
    .slot             (req.slot),
    .after_slot       (req.after_slot),
    .after_is_head    (req.after_is_head),
    .out_valid        (rsp.valid),
    .out_ready        (rsp.ready),
    .status           (rsp.status),
    .granted_slot     (rsp.granted_slot),
    .queued_count     (rsp.queued_count),
    .unreserved_count (rsp.unreserved_count)
  );

endmodule

`default_nettype wire

>>> tb/reservable_linked_queue_unit_tb.sv
// ----------------------------------------------------------------------------
// reservable_linked_queue_unit_tb
// Self-checking bench for the reservable linked queue unit. A shadow copy of
// the list (links, queued and reserved flags, head, tail, counters) predicts
// each response word; requests mix directed corner cases with random
// fill/drain phases, random idling on both channels and long output stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module reservable_linked_queue_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ACTION_W     = rlq_pkg::ACTION_W;
  localparam int HANDLE_W     = rlq_pkg::HANDLE_W;
  localparam int COUNT_W      = rlq_pkg::COUNT_W;
  localparam int NSLOTS       = rlq_pkg::DEF_SLOTS;
  localparam int RANDOM_WORDS = 1225;
  localparam int HOLD_CYCLES  = 300;
  localparam int IDLE_PCT     = 19;
  localparam int MAX_REPORTS  = 10;
  localparam int DRAIN_CYCLES = 2 * NSLOTS + 8;
  localparam int CYCLE_LIMIT  = 400000;

  // Slot choices for random requests
  localparam int PICK_UNQUEUED = 0;
  localparam int PICK_QUEUED   = 1;
  localparam int PICK_RESERVED = 2;

  typedef struct packed {
    rlq_pkg::status_t    status;
    logic [HANDLE_W-1:0] granted;
    logic [COUNT_W-1:0]  queued;
    logic [COUNT_W-1:0]  unreserved;
  } rsp_word_t;

  // Shadow of the queue; predicts and checks response words
  class linked_queue_mirror;
    logic [HANDLE_W-1:0] next_link [NSLOTS];
    bit                  queued    [NSLOTS];
    bit                  reserved  [NSLOTS];
    logic [HANDLE_W-1:0] head;
    logic [HANDLE_W-1:0] tail;
    logic [COUNT_W-1:0]  entries;
    logic [COUNT_W-1:0]  unreserved;
    rsp_word_t           awaited[$];
    int                  mismatches;
    int                  responses;
    int                  grants;
    int                  rejects;
    int                  full_hits;

    function new();
      foreach (next_link[i]) begin
        next_link[i] = '0;
        queued[i]    = 1'b0;
        reserved[i]  = 1'b0;
      end
      head       = '0;
      tail       = '0;
      entries    = '0;
      unreserved = '0;
    endfunction

    function void mark_queued(input logic [HANDLE_W-1:0] s);
      queued[s]   = 1'b1;
      reserved[s] = 1'b0;
      entries++;
      unreserved++;
      if (entries == NSLOTS) full_hits++;
    endfunction

    // Random slot in the wanted state, or a random slot if none is
    function logic [HANDLE_W-1:0] pick_slot(input int kind);
      int                  base;
      bit                  fits;
      logic [HANDLE_W-1:0] s;
      base = $urandom_range(0, NSLOTS - 1);
      for (int k = 0; k < NSLOTS; k++) begin
        s = HANDLE_W'(base + k);
        case (kind)
          PICK_UNQUEUED: fits = !queued[s];
          PICK_QUEUED:   fits = queued[s];
          default:       fits = reserved[s];
        endcase
        if (fits) return s;
      end
      return HANDLE_W'(base);
    endfunction

    // Apply one accepted request and queue the word it must produce
    function void note_request(input logic [ACTION_W-1:0] act,
                               input logic [HANDLE_W-1:0] s,
                               input logic [HANDLE_W-1:0] a,
                               input logic at_head);
      rsp_word_t           w;
      logic [HANDLE_W-1:0] p;
      bit                  hit;
      w.status  = rlq_pkg::ST_MISUSE;
      w.granted = '0;
      hit       = 1'b0;
      case (act)
        rlq_pkg::ACT_APPEND: if (!queued[s]) begin
          next_link[s] = '0;
          if (entries == 0) head = s;
          else next_link[tail] = s;
          tail = s;
          mark_queued(s);
          w.status = rlq_pkg::ST_DONE;
        end
        rlq_pkg::ACT_INSERT: if (!queued[s] && (at_head || queued[a])) begin
          if (at_head) begin
            next_link[s] = (entries != 0) ? head : '0;
            if (entries == 0) tail = s;
            head = s;
          end else begin
            next_link[s] = next_link[a];
            next_link[a] = s;
            if (tail == a) tail = s;
          end
          mark_queued(s);
          w.status = rlq_pkg::ST_DONE;
        end
        rlq_pkg::ACT_RESERVE: begin
          // oldest entry without a reservation, walking from the head
          w.status = rlq_pkg::ST_EMPTY;
          if (unreserved != 0) begin
            p = head;
            for (int i = 0; i < entries && !hit; i++) begin
              if (!reserved[p]) begin
                reserved[p] = 1'b1;
                unreserved--;
                w.granted = p;
                w.status  = rlq_pkg::ST_DONE;
                hit       = 1'b1;
              end else begin
                p = next_link[p];
              end
            end
          end
        end
        rlq_pkg::ACT_COMMIT: if (queued[s] && reserved[s]) begin
          // unlink from any position; find the predecessor unless at head
          hit = (s == head);
          if (hit) begin
            head = next_link[s];
          end else begin
            p = head;
            for (int i = 0; i < entries && !hit; i++) begin
              if (next_link[p] == s) hit = 1'b1;
              else p = next_link[p];
            end
            if (hit) begin
              next_link[p] = next_link[s];
              if (tail == s) tail = p;
            end
          end
          if (hit) begin
            queued[s]   = 1'b0;
            reserved[s] = 1'b0;
            entries--;
            if (entries == 0) begin
              head = '0;
              tail = '0;
            end
            w.status = rlq_pkg::ST_DONE;
          end
        end
        rlq_pkg::ACT_ROLLBACK: if (reserved[s]) begin
          reserved[s] = 1'b0;
          unreserved++;
          w.status = rlq_pkg::ST_DONE;
        end
        default: ;
      endcase
      if (w.status == rlq_pkg::ST_MISUSE) rejects++;
      if (act == rlq_pkg::ACT_RESERVE && w.status == rlq_pkg::ST_DONE) grants++;
      w.queued     = entries;
      w.unreserved = unreserved;
      awaited.push_back(w);
    endfunction

    // Compare one accepted response word with the oldest prediction
    function void check_response(input rsp_word_t got);
      rsp_word_t want;
      responses++;
      if (awaited.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("word %0d: response with none expected (status %0d slot %0d)",
                   responses, int'(got.status), got.granted);
        return;
      end
      want = awaited.pop_front();
      if (got.status !== want.status || got.granted !== want.granted ||
          got.queued !== want.queued || got.unreserved !== want.unreserved) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("word %0d: expected %0d/%0d/%0d/%0d, got %0d/%0d/%0d/%0d",
                   responses,
                   int'(want.status), want.granted, want.queued, want.unreserved,
                   int'(got.status), got.granted, got.queued, got.unreserved);
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  bit   burst_mode;
  bit   stall_request;
  int   hold_left;
  int   holdoffs;
  int   cycles;
  int   errors;

  linked_queue_mirror shadow = new();

  rlq_in_if  req_ch();
  rlq_out_if rsp_ch();

  reservable_linked_queue_unit dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run limit
  initial cycles = 0;
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Response side: random back-pressure, plus long hold-offs on request
  initial begin
    rsp_ch.ready = 1'b0;
    hold_left    = 0;
    holdoffs     = 0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        hold_left--;
        rsp_ch.ready <= 1'b0;
      end else if (stall_request) begin
        stall_request = 1'b0;
        hold_left     = HOLD_CYCLES - 1;
        holdoffs++;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= burst_mode || ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  // Response monitor
  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready)
      shadow.check_response({rsp_ch.status, rsp_ch.granted_slot,
                             rsp_ch.queued_count, rsp_ch.unreserved_count});
  end

  // Offer one request word, with random idle cycles ahead of it
  task automatic send_request(input logic [ACTION_W-1:0] act,
                              input logic [HANDLE_W-1:0] s,
                              input logic [HANDLE_W-1:0] a,
                              input logic at_head);
    while (!burst_mode && $urandom_range(0, 99) < IDLE_PCT) begin
      @(negedge clk);
      req_ch.valid <= 1'b0;
    end
    @(negedge clk);
    req_ch.valid         <= 1'b1;
    req_ch.action        <= act;
    req_ch.slot          <= s;
    req_ch.after_slot    <= a;
    req_ch.after_is_head <= at_head;
    do @(posedge clk); while (!req_ch.ready);
    shadow.note_request(act, s, a, at_head);
  endtask

  // Mostly well-formed requests chosen from the shadow state, some noise
  task automatic random_request(input bit filling);
    int                  pick;
    logic [ACTION_W-1:0] act;
    logic [HANDLE_W-1:0] s;
    logic [HANDLE_W-1:0] a;
    logic                h;
    pick = $urandom_range(0, 99);
    act  = rlq_pkg::ACT_RESERVE;
    s    = HANDLE_W'($urandom);
    a    = HANDLE_W'($urandom);
    h    = 1'($urandom);
    if (pick < 8) begin
      act = ACTION_W'($urandom);
    end else if (pick < (filling ? 40 : 18)) begin
      act = rlq_pkg::ACT_APPEND;
      s   = shadow.pick_slot(PICK_UNQUEUED);
    end else if (pick < (filling ? 62 : 26)) begin
      act = rlq_pkg::ACT_INSERT;
      s   = shadow.pick_slot(PICK_UNQUEUED);
      h   = ($urandom_range(0, 3) == 0);
      if (!h) a = shadow.pick_slot(PICK_QUEUED);
    end else if (pick < (filling ? 78 : 62)) begin
      act = rlq_pkg::ACT_RESERVE;
    end else if (pick < 92) begin
      act = rlq_pkg::ACT_COMMIT;
      s   = shadow.pick_slot(PICK_RESERVED);
    end else begin
      act = rlq_pkg::ACT_ROLLBACK;
      s   = shadow.pick_slot(PICK_RESERVED);
    end
    send_request(act, s, a, h);
  endtask

  task automatic wait_drained();
    while (shadow.awaited.size() != 0) @(posedge clk);
  endtask

  // Stimulus
  initial begin
    rst                  = 1'b1;
    burst_mode           = 1'b0;
    stall_request        = 1'b0;
    req_ch.valid         = 1'b0;
    req_ch.action        = rlq_pkg::ACT_APPEND;
    req_ch.slot          = '0;
    req_ch.after_slot    = '0;
    req_ch.after_is_head = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: misuse and an empty reserve on an empty queue
    send_request(rlq_pkg::ACT_RESERVE,  4'd0,  4'd0,  1'b0);   // nothing to reserve
    send_request(rlq_pkg::ACT_COMMIT,   4'd0,  4'd0,  1'b0);   // commit of unreserved
    send_request(rlq_pkg::ACT_ROLLBACK, 4'd15, 4'd0,  1'b0);   // rollback of unreserved
    send_request(rlq_pkg::ACT_INSERT,   4'd2,  4'd3,  1'b0);   // after unqueued slot
    // build 0 -> 9 -> 15 -> 7
    send_request(rlq_pkg::ACT_APPEND,   4'd15, 4'd0,  1'b0);   // into empty queue
    send_request(rlq_pkg::ACT_APPEND,   4'd15, 4'd0,  1'b0);   // write of queued slot
    send_request(rlq_pkg::ACT_INSERT,   4'd0,  4'd15, 1'b1);   // at head
    send_request(rlq_pkg::ACT_INSERT,   4'd7,  4'd15, 1'b0);   // behind tail
    send_request(rlq_pkg::ACT_INSERT,   4'd9,  4'd0,  1'b0);   // mid-list
    for (int k = int'(rlq_pkg::ACT_ROLLBACK) + 1; k < 2 ** ACTION_W; k++)
      send_request(ACTION_W'(k), 4'd9, 4'd15, 1'b1);   // unknown actions
    repeat (5) send_request(rlq_pkg::ACT_RESERVE, 4'd15, 4'd15, 1'b1);
    send_request(rlq_pkg::ACT_ROLLBACK, 4'd9,  4'd0,  1'b0);
    send_request(rlq_pkg::ACT_RESERVE,  4'd0,  4'd0,  1'b0);   // takes 9 again
    // commits: middle, tail, head, last entry
    send_request(rlq_pkg::ACT_COMMIT,   4'd15, 4'd0,  1'b0);
    send_request(rlq_pkg::ACT_COMMIT,   4'd7,  4'd0,  1'b0);
    send_request(rlq_pkg::ACT_COMMIT,   4'd0,  4'd0,  1'b0);
    send_request(rlq_pkg::ACT_COMMIT,   4'd9,  4'd0,  1'b0);
    send_request(rlq_pkg::ACT_INSERT,   4'd5,  4'd10, 1'b1);   // head insert, empty queue
    send_request(rlq_pkg::ACT_COMMIT,   4'd5,  4'd0,  1'b0);
    send_request(rlq_pkg::ACT_RESERVE,  4'd0,  4'd0,  1'b0);
    send_request(rlq_pkg::ACT_COMMIT,   4'd5,  4'd0,  1'b0);

    // random: alternating fill and drain phases
    for (int i = 0; i < RANDOM_WORDS; i++) begin
      if (i == 300 || i == 1000) stall_request = 1'b1;
      if (i == 600) begin
        @(negedge clk);
        req_ch.valid <= 1'b0;
        wait_drained();
      end
      burst_mode = (i >= 700 && i < 950);
      random_request((i / 80) % 2 == 0);
    end
    @(negedge clk);
    req_ch.valid <= 1'b0;
    burst_mode = 1'b0;

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    errors = shadow.mismatches + shadow.awaited.size();

    $display("covered %0d words in %0d cycles: %0d grants, %0d rejected as misuse",
             shadow.responses, cycles, shadow.grants, shadow.rejects);
    $display("queue reached all %0d slots %0d times; %0d long output hold-offs; %0d errors",
             NSLOTS, shadow.full_hits, holdoffs, errors);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
